// ===== hdl/mhd_pkg.sv =====
// shared types, widths and helpers of the rgb mahalanobis distance block
package mhd_pkg;

  localparam int unsigned CHANNEL_COUNT = 3;
  localparam int unsigned PAIR_COUNT    = CHANNEL_COUNT * (CHANNEL_COUNT + 1) / 2;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned MEAN_W    = 16;
  localparam int unsigned COEF_W    = 32;
  localparam int unsigned CFG_W     = CHANNEL_COUNT * MEAN_W;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DIST_W    = 16;
  localparam int unsigned GREY_W    = 8;

  // q8.8 difference, product of two differences, product with q8.24 coefficient
  localparam int unsigned DIFF_W    = MEAN_W + 1;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned TERM_W    = 64;
  localparam int unsigned SUM_W     = TERM_W + 4;
  localparam int unsigned FRAC_BITS = 40;

  // square root operand and result
  localparam int unsigned RAD_W      = SUM_W - FRAC_BITS;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned REM_W      = ROOT_W + 3;
  localparam int unsigned SQRT_STEPS = 2;
  localparam int unsigned SQRT_STAGES = ROOT_W / SQRT_STEPS;

  localparam int unsigned QUAD_STAGES = 5;
  localparam int unsigned LATENCY     = QUAD_STAGES + SQRT_STAGES + 1;

  // channel pairs of the quadratic form: rr, gg, bb, rg, rb, gb
  localparam int unsigned PAIR_A [PAIR_COUNT] = '{0, 1, 2, 0, 0, 1};
  localparam int unsigned PAIR_B [PAIR_COUNT] = '{0, 1, 2, 1, 2, 2};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MEAN = 3'd0,
    REG_RR   = 3'd1,
    REG_GG   = 3'd2,
    REG_BB   = 3'd3,
    REG_RG   = 3'd4,
    REG_RB   = 3'd5,
    REG_GB   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [GREY_W-1:0] grey_byte;
  } result_t;

  typedef struct packed {
    logic [CHANNEL_COUNT-1:0][MEAN_W-1:0] mean;
    logic [PAIR_COUNT-1:0][COEF_W-1:0]    coef;
  } cfg_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // one digit of the restoring square root
  function automatic sq_t sqrt_step(sq_t s);
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    sq_t              r;
    acc   = {s.rem[REM_W-4:0], s.rad[RAD_W-1 -: 2]};
    trial = REM_W'({s.root, 2'b01});
    r.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

// ===== hdl/mhd_cfg_regs.sv =====
// configuration registers: mean vector and inverse covariance coefficients
module mhd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mhd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mhd_pkg::CFG_W-1:0]      cfg_wdata_i,
  output mhd_pkg::cfg_t                  cfg_o
);
  import mhd_pkg::*;

  logic [CFG_W-1:0]                  mean_q;
  logic [PAIR_COUNT-1:0][COEF_W-1:0] coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
      coef_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_MEAN: mean_q    <= cfg_wdata_i;
        REG_RR:   coef_q[0] <= cfg_wdata_i[COEF_W-1:0];
        REG_GG:   coef_q[1] <= cfg_wdata_i[COEF_W-1:0];
        REG_BB:   coef_q[2] <= cfg_wdata_i[COEF_W-1:0];
        REG_RG:   coef_q[3] <= cfg_wdata_i[COEF_W-1:0];
        REG_RB:   coef_q[4] <= cfg_wdata_i[COEF_W-1:0];
        REG_GB:   coef_q[5] <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.mean = mean_q;
  assign cfg_o.coef = coef_q;

endmodule

// ===== hdl/mhd_quad_form.sv =====
// five stage pipeline: mean subtraction, products, coefficient products, sums, clamp
module mhd_quad_form (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  mhd_pkg::pixel_t           pixel_i,
  input  mhd_pkg::cfg_t             cfg_i,
  output logic                      valid_o,
  output logic [mhd_pkg::RAD_W-1:0] whole_o
);
  import mhd_pkg::*;

  logic [CH_W-1:0]          px_w [CHANNEL_COUNT];
  logic signed [DIFF_W-1:0] d_d [CHANNEL_COUNT];
  logic signed [DIFF_W-1:0] d_q [CHANNEL_COUNT];
  logic signed [PROD_W-1:0] p_d [PAIR_COUNT];
  logic signed [PROD_W-1:0] p_q [PAIR_COUNT];
  logic signed [TERM_W-1:0] t_d [PAIR_COUNT];
  logic signed [TERM_W-1:0] t_q [PAIR_COUNT];
  logic signed [SUM_W-1:0]  diag_d, diag_q;
  logic signed [SUM_W-1:0]  off_d, off_q;
  logic signed [SUM_W-1:0]  total_w;
  logic [RAD_W-1:0]         whole_d, whole_q;
  logic [QUAD_STAGES-1:0]   vld_q;

  assign px_w[0] = pixel_i.red;
  assign px_w[1] = pixel_i.green;
  assign px_w[2] = pixel_i.blue;

  // stage 1: pixel widened to q8.8 minus mean
  always_comb begin
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      d_d[c] = $signed({1'b0, px_w[c], 8'h00}) - $signed({1'b0, cfg_i.mean[c]});
    end
  end

  // stage 2: products of channel differences
  always_comb begin
    for (int k = 0; k < PAIR_COUNT; k++) begin
      p_d[k] = PROD_W'(d_q[PAIR_A[k]]) * PROD_W'(d_q[PAIR_B[k]]);
    end
  end

  // stage 3: times the q8.24 coefficient, 40 fraction bits
  always_comb begin
    for (int k = 0; k < PAIR_COUNT; k++) begin
      t_d[k] = TERM_W'(p_q[k]) * TERM_W'($signed(cfg_i.coef[k]));
    end
  end

  // stage 4: diagonal and off-diagonal partial sums
  assign diag_d = SUM_W'(t_q[0]) + SUM_W'(t_q[1]) + SUM_W'(t_q[2]);
  assign off_d  = SUM_W'(t_q[3]) + SUM_W'(t_q[4]) + SUM_W'(t_q[5]);

  // stage 5: off-diagonal terms count twice, drop fraction, clamp negative to zero
  assign total_w = diag_q + (off_q <<< 1);
  assign whole_d = total_w[SUM_W-1] ? '0 : total_w[SUM_W-1:FRAC_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QUAD_STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    d_q     <= d_d;
    p_q     <= p_d;
    t_q     <= t_d;
    diag_q  <= diag_d;
    off_q   <= off_d;
    whole_q <= whole_d;
  end

  assign valid_o = vld_q[QUAD_STAGES-1];
  assign whole_o = whole_q;

endmodule

// ===== hdl/mhd_isqrt.sv =====
// pipelined integer square root, two result bits per stage
module mhd_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [mhd_pkg::RAD_W-1:0]  rad_i,
  output logic                       valid_o,
  output logic [mhd_pkg::ROOT_W-1:0] root_o
);
  import mhd_pkg::*;

  sq_t  st_q  [SQRT_STAGES];
  logic vld_q [SQRT_STAGES];

  for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
    sq_t  in_w;
    sq_t  nxt_w;
    logic in_vld_w;

    if (s == 0) begin : g_first
      assign in_w.rad  = rad_i;
      assign in_w.rem  = '0;
      assign in_w.root = '0;
      assign in_vld_w  = valid_i;
    end else begin : g_next
      assign in_w     = st_q[s-1];
      assign in_vld_w = vld_q[s-1];
    end

    always_comb begin
      nxt_w = in_w;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        nxt_w = sqrt_step(nxt_w);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= in_vld_w;
      end
    end

    always_ff @(posedge clk_i) begin
      st_q[s] <= nxt_w;
    end
  end

  assign valid_o = vld_q[SQRT_STAGES-1];
  assign root_o  = st_q[SQRT_STAGES-1].root;

endmodule

// ===== hdl/pixel_mahalanobis_distance.sv =====
// top level: mahalanobis distance of an rgb pixel from a configured mean
//
// Usage: a request (one pixel, fields red/green/blue) is taken at a rising
// edge where start is high and busy is low. busy never rises, so one pixel
// can enter on every clock; there is no dependence between pixels.
// Each request gives one result on result_o, marked by done_o for exactly
// one cycle. Results leave in request order. Throughput is one pixel per
// cycle. Latency is set by five stages for the quadratic form (mean
// subtraction, difference products, coefficient products, partial sums,
// final sum and clamp), seven square root stages at two root bits each,
// and the output register.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i at the
// edge; index 7 is ignored. Write only while no request is in flight.
// Reset zeroes the configuration registers and empties the pipeline. The
// receiver cannot stall: a result is shown for one cycle only.
module pixel_mahalanobis_distance (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  mhd_pkg::pixel_t               pixel_i,
  input  logic                          cfg_we_i,
  input  logic [mhd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mhd_pkg::CFG_W-1:0]     cfg_wdata_i,
  output logic                          done_o,
  output mhd_pkg::result_t              result_o
);
  import mhd_pkg::*;

  cfg_t              cfg_w;
  logic              quad_vld_w;
  logic [RAD_W-1:0]  whole_w;
  logic              root_vld_w;
  logic [ROOT_W-1:0] root_w;
  logic              done_q;
  result_t           result_d, result_q;
  logic              accept_w;

  assign busy     = 1'b0;
  assign accept_w = start && !busy;

  mhd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg_w)
  );

  mhd_quad_form u_quad_form (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept_w),
    .pixel_i (pixel_i),
    .cfg_i   (cfg_w),
    .valid_o (quad_vld_w),
    .whole_o (whole_w)
  );

  mhd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (quad_vld_w),
    .rad_i   (whole_w),
    .valid_o (root_vld_w),
    .root_o  (root_w)
  );

  // root is below 2^14, so the 16-bit distance never saturates
  assign result_d.distance  = DIST_W'(root_w);
  assign result_d.grey_byte = root_w[GREY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= root_vld_w;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== hdl/mhd_checker.sv =====
// port level checks of the distance block, bound to the top level
module mhd_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input mhd_pkg::pixel_t  pixel_i,
  input logic             cfg_we_i,
  input logic             done_o,
  input mhd_pkg::result_t result_o
);
  import mhd_pkg::*;

  // every request yields a result after the fixed latency
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("request without result");

  // no result without a request at the matching edge
  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without request");

  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.grey_byte == result_o.distance[GREY_W-1:0]))
    else $error("grey byte differs from distance");

  // two back to back equal pixels under unchanged config give equal results
  a_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o) &&
     ($past(pixel_i, LATENCY) == $past(pixel_i, LATENCY + 1)) &&
     !$past(cfg_we_i, LATENCY + 1) && !$past(cfg_we_i, LATENCY) &&
     !$past(cfg_we_i, LATENCY - 1))
    |-> (result_o == $past(result_o)))
    else $error("equal pixels gave different results");

endmodule

bind pixel_mahalanobis_distance mhd_checker u_mhd_checker (.*);

// ===== tb/pixel_mahalanobis_distance_test.sv =====
// testbench for the rgb pixel mahalanobis distance block, checked against a local predictor
`timescale 1ns / 100ps

module pixel_mahalanobis_distance_test;
  import mhd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [COEF_W-1:0] ONE_Q824       = 32'h0100_0000;
  localparam logic [COEF_W-1:0] MINUS_ONE_Q824 = 32'hFF00_0000;
  localparam logic [COEF_W-1:0] COEF_MAX       = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN       = 32'h8000_0000;
  localparam int unsigned PHASE_COUNT     = 10;
  localparam int unsigned ITEMS_PER_PHASE = 70;
  localparam int unsigned CYCLE_LIMIT     = 200000;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
    pixel_t               px;
    bit                   known;
    logic [DIST_W-1:0]    want_dist;
  } stim_row_t;

  typedef struct {
    pixel_t  px;
    result_t res;
  } pending_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  pixel_t               pixel_i;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 done_o;
  result_t              result_o;

  // shadow copy of the block's registers
  logic [CFG_W-1:0]         mean_shadow;
  logic signed [COEF_W-1:0] coef_shadow [8];

  pending_t    pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;

  pixel_mahalanobis_distance DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .pixel_i    (pixel_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pixel_mahalanobis_distance_test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // exact quadratic form, truncated, clamped at zero, then floor square root
  function automatic result_t predict_distance(input pixel_t px);
    logic signed [127:0] diff [3];
    logic signed [127:0] acc;
    logic [63:0]         whole;
    logic [63:0]         root;
    logic [127:0]        trial;
    logic [7:0]          chan [3];
    result_t             r;
    chan[0] = px.red;
    chan[1] = px.green;
    chan[2] = px.blue;
    for (int c = 0; c < 3; c++) begin
      diff[c] = $signed({112'd0, chan[c], 8'd0})
              - $signed({112'd0, mean_shadow[16*c +: 16]});
    end
    acc = diff[0] * diff[0] * 128'(coef_shadow[REG_RR])
        + diff[1] * diff[1] * 128'(coef_shadow[REG_GG])
        + diff[2] * diff[2] * 128'(coef_shadow[REG_BB])
        + 2 * diff[0] * diff[1] * 128'(coef_shadow[REG_RG])
        + 2 * diff[0] * diff[2] * 128'(coef_shadow[REG_RB])
        + 2 * diff[1] * diff[2] * 128'(coef_shadow[REG_GB]);
    if (acc < 0) whole = '0;
    else whole = acc[103:40];
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = {64'd0, root | (64'd1 << b)};
      if (trial * trial <= {64'd0, whole}) root = trial[63:0];
    end
    if (root > 64'd65535) root = 64'd65535;
    r.distance  = root[15:0];
    r.grey_byte = root[7:0];
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] data);
    stim_row_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.data   = data;
    return s;
  endfunction

  function automatic stim_row_t pix_row(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    stim_row_t s;
    s = '{default: '0};
    s.px = '{red: r, green: g, blue: b};
    return s;
  endfunction

  function automatic stim_row_t pix_known(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [15:0] want_dist);
    stim_row_t s;
    s           = pix_row(r, g, b);
    s.known     = 1'b1;
    s.want_dist = want_dist;
    return s;
  endfunction

  // called at a rising edge; returns at the edge that accepts the request
  task automatic send_pixel(input pixel_t px, input bit known, input logic [15:0] want_dist);
    logic     stalled;
    pending_t p;
    start   <= 1'b1;
    pixel_i <= px;
    do begin
      @(negedge clk_i);
      stalled = busy;
      @(posedge clk_i);
    end while (stalled);
    p.px = px;
    if (known) p.res = '{distance: want_dist, grey_byte: want_dist[7:0]};
    else p.res = predict_distance(px);
    pending_results.push_back(p);
  endtask

  task automatic idle_gap(input bit allow);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 99);
    n = 0;
    if (allow && r >= 60) n = (r < 96) ? $urandom_range(1, 3) : $urandom_range(20, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // one register write per edge; the caller lowers the write enable afterwards
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      REG_MEAN: mean_shadow = data;
      REG_RR, REG_GG, REG_BB, REG_RG, REG_RB, REG_GB: coef_shadow[idx] = data[COEF_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_setting(input int unsigned style);
    logic [CFG_W-1:0]  mean;
    logic [COEF_W-1:0] coef;
    int unsigned       pick;
    pick = $urandom_range(0, 9);
    if (style == 0) mean = '0;
    else if (style == 1 || pick == 0) mean = '1;
    else if (pick == 1) mean = '0;
    else mean = {16'($urandom()), 32'($urandom())};
    write_reg(REG_MEAN, mean);
    for (int i = REG_RR; i <= REG_GB; i++) begin
      case (style)
        0: coef = COEF_MAX;
        1: coef = COEF_MIN;
        2: coef = $urandom();
        // mostly positive definite so that distances spread out
        default: coef = (i <= REG_BB) ? 32'($urandom_range(0, 32'h0800_0000))
                                      : 32'($urandom_range(0, 32'h0080_0000)) - 32'h0040_0000;
      endcase
      write_reg(3'(i), {16'($urandom()), coef});
    end
    if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, {16'($urandom()), 32'($urandom())});
    cfg_we_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    pending_t p;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result %0d/%0d", result_o.distance,
                                  result_o.grey_byte));
      end else begin
        p = pending_results.pop_front();
        if (result_o.distance !== p.res.distance)
          report_mismatch($sformatf("pixel %02h %02h %02h distance %0d, predicted %0d",
                                    p.px.red, p.px.green, p.px.blue,
                                    result_o.distance, p.res.distance));
        if (result_o.grey_byte !== p.res.grey_byte)
          report_mismatch($sformatf("pixel %02h %02h %02h grey %0d, predicted %0d",
                                    p.px.red, p.px.green, p.px.blue,
                                    result_o.grey_byte, p.res.grey_byte));
      end
    end
  end

  initial begin
    pixel_t      px;
    bit          writing;
    bit          gaps_on;
    int unsigned style;
    rst_ni         = 1'b0;
    start          = 1'b0;
    pixel_i        = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    mean_shadow    = '0;
    foreach (coef_shadow[i]) coef_shadow[i] = '0;

    directed_rows = '{
      // registers still at reset
      pix_known(8'd0, 8'd0, 8'd0, 16'd0),
      pix_known(8'd255, 8'd255, 8'd255, 16'd0),
      pix_known(8'hAA, 8'h55, 8'h0F, 16'd0),
      // write to the unused index is dropped
      cfg_row(REG_UNUSED, 48'hFFFF_FFFF_FFFF),
      pix_known(8'd255, 8'd255, 8'd255, 16'd0),
      // identity on red, upper data bits ignored: distance equals red
      cfg_row(REG_RR, {16'hFFFF, ONE_Q824}),
      pix_known(8'd0, 8'd0, 8'd0, 16'd0),
      pix_known(8'd255, 8'd0, 8'd0, 16'd255),
      pix_known(8'd1, 8'd200, 8'd3, 16'd1),
      pix_known(8'd128, 8'd77, 8'd9, 16'd128),
      // negative form clamps to zero
      cfg_row(REG_RR, {16'h0000, MINUS_ONE_Q824}),
      pix_known(8'd255, 8'd0, 8'd0, 16'd0),
      pix_known(8'd17, 8'd250, 8'd0, 16'd0),
      cfg_row(REG_RR, {16'h0000, ONE_Q824}),
      cfg_row(REG_MEAN, 48'h0000_0000_FF00),
      pix_known(8'd255, 8'd9, 8'd9, 16'd0),
      pix_known(8'd0, 8'd9, 8'd9, 16'd255),
      cfg_row(REG_MEAN, 48'h0000_0000_0080),
      pix_row(8'd0, 8'd0, 8'd0),
      pix_row(8'd1, 8'd0, 8'd0),
      // coefficient and mean extremes
      cfg_row(REG_MEAN, 48'hFFFF_FFFF_FFFF),
      cfg_row(REG_RR, {16'h0000, COEF_MAX}),
      cfg_row(REG_GG, {16'h0000, COEF_MAX}),
      cfg_row(REG_BB, {16'h0000, COEF_MAX}),
      cfg_row(REG_RG, {16'h0000, COEF_MAX}),
      cfg_row(REG_RB, {16'h0000, COEF_MAX}),
      cfg_row(REG_GB, {16'h0000, COEF_MAX}),
      pix_row(8'd0, 8'd0, 8'd0),
      pix_row(8'd255, 8'd255, 8'd255),
      cfg_row(REG_MEAN, 48'h0000_0000_0000),
      pix_row(8'd255, 8'd255, 8'd255),
      pix_known(8'd0, 8'd0, 8'd0, 16'd0),
      cfg_row(REG_RR, {16'h0000, COEF_MIN}),
      cfg_row(REG_GG, {16'h0000, COEF_MIN}),
      cfg_row(REG_BB, {16'h0000, COEF_MIN}),
      cfg_row(REG_RG, {16'h0000, COEF_MIN}),
      cfg_row(REG_RB, {16'h0000, COEF_MIN}),
      cfg_row(REG_GB, {16'h0000, COEF_MIN}),
      pix_known(8'd255, 8'd255, 8'd255, 16'd0),
      pix_row(8'd255, 8'd0, 8'd128),
      // indefinite matrix: sign depends on the pixel
      cfg_row(REG_RR, {16'h0000, ONE_Q824}),
      cfg_row(REG_GG, {16'h0000, MINUS_ONE_Q824}),
      cfg_row(REG_BB, 48'd0),
      cfg_row(REG_RG, 48'd0),
      cfg_row(REG_RB, 48'd0),
      cfg_row(REG_GB, 48'd0),
      pix_known(8'd10, 8'd20, 8'd0, 16'd0),
      pix_row(8'd20, 8'd10, 8'd0)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    writing = 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        if (!writing) wait_drained();
        writing = 1'b1;
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        if (writing) cfg_we_i <= 1'b0;
        writing = 1'b0;
        send_pixel(directed_rows[i].px, directed_rows[i].known,
                   directed_rows[i].want_dist);
        idle_gap(1'b1);
      end
    end

    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_drained();
      style = (phase < 2) ? phase : ((phase % 3 == 0) ? 2 : 3);
      load_setting(style);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        px.red   = ($urandom_range(0, 9) == 0) ? {8{1'($urandom())}} : 8'($urandom());
        px.green = ($urandom_range(0, 9) == 0) ? {8{1'($urandom())}} : 8'($urandom());
        px.blue  = ($urandom_range(0, 9) == 0) ? {8{1'($urandom())}} : 8'($urandom());
        send_pixel(px, 1'b0, '0);
        // hold off the source mid-phase until the pipeline is empty
        if (phase == 4 && n == ITEMS_PER_PHASE / 2) wait_drained();
        else idle_gap(gaps_on);
      end
    end

    wait_drained();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_count == 0) begin
      $display("pixel_mahalanobis_distance_test passed");
    end else begin
      $display("pixel_mahalanobis_distance_test failed");
    end
    $finish;
  end

endmodule
